>>> hw/rtl/isotp_frame_reassembler_unit_assert.svh
// ----------------------------------------------------------------------------
// isotp frame reassembler assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ISOTP_FRAME_REASSEMBLER_UNIT_ASSERT_SVH
`define ISOTP_FRAME_REASSEMBLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ISOTP_FR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ISOTP_FR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ISOTP_FR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISOTP_FR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hw/rtl/isotp_fr_pkg.sv
// ----------------------------------------------------------------------------
// isotp_fr_pkg
// shared widths, protocol codes and memory request type of the reassembler
// ----------------------------------------------------------------------------
package isotp_fr_pkg;

    localparam int ID_W          = 29;
    localparam int DLC_W         = 4;
    localparam int LEN_W         = 9;
    localparam int BYTES_PER_ROW = 8;
    localparam int ROW_ADDR_W    = LEN_W - 3;
    localparam int MSG_CAP_DEF   = 256;
    localparam int CFG_IDX_W     = 1;

    localparam logic [ID_W-1:0] FUNC_IDENT_RST = 29'h7DF;
    localparam logic [3:0]      SF_MAX_LEN     = 4'd7;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RX_IDENT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_IDENT = 1'b1;

    // frame type codes in the high nibble of byte 0
    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    typedef logic [BYTES_PER_ROW-1:0][7:0] t_row;

    typedef struct packed {
        logic                  we;
        logic [ROW_ADDR_W-1:0] waddr;
        logic [BYTES_PER_ROW-1:0] be;
        t_row                  wdata;
        logic                  re;
        logic [ROW_ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

>>> hw/rtl/isotp_fr_in_if.sv
// ----------------------------------------------------------------------------
// isotp_fr_in_if
// channel carrying one received can frame per item
// ----------------------------------------------------------------------------
interface isotp_fr_in_if;
    import isotp_fr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   can_ident;
    logic [DLC_W-1:0]  frame_len;
    logic [7:0]        byte_0;
    logic [7:0]        byte_1;
    logic [7:0]        byte_2;
    logic [7:0]        byte_3;
    logic [7:0]        byte_4;
    logic [7:0]        byte_5;
    logic [7:0]        byte_6;
    logic [7:0]        byte_7;

    modport source (
        output valid, can_ident, frame_len,
        output byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
        input  ready
    );
    modport sink (
        input  valid, can_ident, frame_len,
        input  byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
        output ready
    );
endinterface

>>> hw/rtl/isotp_fr_out_if.sv
// ----------------------------------------------------------------------------
// isotp_fr_out_if
// channel carrying one 8-byte message word per item
// ----------------------------------------------------------------------------
interface isotp_fr_out_if;
    import isotp_fr_pkg::*;

    logic              valid;
    logic              ready;
    logic [7:0]        out_0;
    logic [7:0]        out_1;
    logic [7:0]        out_2;
    logic [7:0]        out_3;
    logic [7:0]        out_4;
    logic [7:0]        out_5;
    logic [7:0]        out_6;
    logic [7:0]        out_7;
    logic [3:0]        word_bytes;
    logic [LEN_W-1:0]  message_length;
    logic              last_word;

    modport source (
        output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
        output word_bytes, message_length, last_word,
        input  ready
    );
    modport sink (
        input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
        input  word_bytes, message_length, last_word,
        output ready
    );
endinterface

>>> hw/rtl/isotp_fr_mem.sv
// ----------------------------------------------------------------------------
// isotp_fr_mem
// message buffer: rows of eight bytes, byte-enable write, registered read
// ----------------------------------------------------------------------------
module isotp_fr_mem #(
    parameter int MSG_CAP = isotp_fr_pkg::MSG_CAP_DEF
) (
    input  logic                   i_clk,
    input  isotp_fr_pkg::t_mem_req i_req,
    output isotp_fr_pkg::t_row     o_rdata
);
    import isotp_fr_pkg::*;

    localparam int ROWS  = (MSG_CAP + BYTES_PER_ROW - 1) / BYTES_PER_ROW;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    t_row r_mem [ROWS];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            for (int l = 0; l < BYTES_PER_ROW; l++) begin
                if (i_req.be[l]) begin
                    r_mem[i_req.waddr[ROW_W-1:0]][l] <= i_req.wdata[l];
                end
            end
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[ROW_W-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/isotp_fr_ctrl.sv
// ----------------------------------------------------------------------------
// isotp_fr_ctrl
// frame decode, reassembly state, buffer writes and message drain sequencer
// ----------------------------------------------------------------------------
module isotp_fr_ctrl #(
    parameter int MSG_CAP = isotp_fr_pkg::MSG_CAP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [isotp_fr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [isotp_fr_pkg::ID_W-1:0]       i_cfg_data,
    isotp_fr_in_if.sink                         i_frm,
    isotp_fr_out_if.source                      o_word,
    output isotp_fr_pkg::t_mem_req              o_mem_req,
    input  isotp_fr_pkg::t_row                  i_rdata
);
    import isotp_fr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WR_LO,
        ST_WR_HI,
        ST_RD,
        ST_RDW
    } t_state;

    t_state            r_state;
    logic [ID_W-1:0]   r_rx_id;
    logic [ID_W-1:0]   r_fn_id;
    logic              r_receiving;
    logic [LEN_W-1:0]  r_total;
    logic [LEN_W-1:0]  r_recv;
    logic [3:0]        r_seq;

    // captured frame
    logic [ID_W-1:0]   r_id;
    logic [DLC_W-1:0]  r_dlc;
    t_row              r_d;

    // pending buffer write
    logic [LEN_W-1:0]  r_wpos;
    logic [2:0]        r_wcnt;
    t_row              r_wdata;
    logic              r_done;
    logic [LEN_W-1:0]  r_pos;

    // output register
    logic              r_ovalid;
    t_row              r_ob;
    logic [3:0]        r_obytes;
    logic [LEN_W-1:0]  r_olen;
    logic              r_olast;

    logic [3:0]        dlc_sat;
    logic              id_hit;
    logic [3:0]        pci;
    logic [3:0]        nib;
    logic              out_free;
    logic              out_load;
    logic              sf_ok;
    t_row              sf_row;
    logic [11:0]       ff_len;
    logic              ff_ok;
    logic [2:0]        ff_got;
    t_row              ff_data;
    logic [LEN_W-1:0]  cf_remaining;
    logic [3:0]        cf_avail;
    logic [2:0]        cf_take;
    t_row              cf_data;
    logic [LEN_W-1:0]  cf_recv_new;
    logic [7:0]        lane_mask;
    logic [2:0]        woff;
    logic [2*BYTES_PER_ROW*8-1:0] win_bits;
    logic [2*BYTES_PER_ROW-1:0]   win_be;
    logic [LEN_W-1:0]  drain_rem;
    logic [3:0]        drain_n;
    logic              drain_last;
    t_row              drain_row;

    assign dlc_sat  = (r_dlc > 4'd8) ? 4'd8 : r_dlc;
    assign id_hit   = (r_id == r_rx_id) || (r_id == r_fn_id);
    assign pci      = r_d[0][7:4];
    assign nib      = r_d[0][3:0];
    assign out_free = !r_ovalid || o_word.ready;

    // the output register takes a word from decode or from the drain
    assign out_load = out_free && (((r_state == ST_DECODE) && id_hit && (dlc_sat != 4'd0)
                                    && (pci == PCI_SINGLE) && sf_ok) || (r_state == ST_RDW));

    // single frame
    assign sf_ok = (nib != 4'd0) && (nib <= SF_MAX_LEN) && (nib <= dlc_sat - 4'd1);
    always_comb begin
        for (int i = 0; i < BYTES_PER_ROW; i++) begin
            sf_row[i] = (4'(i) < nib && i < 7) ? r_d[3'(i + 1)] : 8'd0;
        end
    end

    // first frame
    assign ff_len = {nib, r_d[1]};
    assign ff_ok  = (dlc_sat >= 4'd2) && (ff_len >= 12'd8) && (ff_len <= 12'(MSG_CAP));
    assign ff_got = 3'(dlc_sat - 4'd2);
    always_comb begin
        for (int k = 0; k < BYTES_PER_ROW; k++) begin
            ff_data[k] = (k < 6) ? r_d[3'(k + 2)] : 8'd0;
        end
    end

    // consecutive frame
    assign cf_remaining = (r_total > r_recv) ? (r_total - r_recv) : '0;
    assign cf_avail     = dlc_sat - 4'd1;
    assign cf_take      = (LEN_W'(cf_avail) > cf_remaining) ? cf_remaining[2:0]
                                                             : cf_avail[2:0];
    assign cf_recv_new  = r_recv + LEN_W'(cf_take);
    always_comb begin
        for (int k = 0; k < BYTES_PER_ROW; k++) begin
            cf_data[k] = (k < 7) ? r_d[3'(k + 1)] : 8'd0;
        end
    end

    // bytes land across at most two rows: align into a two-row window
    assign lane_mask = 8'((9'd1 << r_wcnt) - 9'd1);
    assign woff      = r_wpos[2:0];
    assign win_bits  = {64'd0, r_wdata} << {woff, 3'b000};
    assign win_be    = {8'd0, lane_mask} << woff;

    // drain
    assign drain_rem  = r_total - r_pos;
    assign drain_n    = (drain_rem > LEN_W'(8)) ? 4'd8 : drain_rem[3:0];
    assign drain_last = (r_pos + LEN_W'(drain_n)) >= r_total;
    always_comb begin
        for (int i = 0; i < BYTES_PER_ROW; i++) begin
            drain_row[i] = (4'(i) < drain_n) ? i_rdata[i] : 8'd0;
        end
    end

    always_comb begin
        o_mem_req       = '0;
        o_mem_req.raddr = r_pos[LEN_W-1:3];
        case (r_state)
            ST_WR_LO: begin
                o_mem_req.we    = |win_be[7:0];
                o_mem_req.waddr = r_wpos[LEN_W-1:3];
                o_mem_req.be    = win_be[7:0];
                o_mem_req.wdata = win_bits[63:0];
            end
            ST_WR_HI: begin
                o_mem_req.we    = |win_be[15:8];
                o_mem_req.waddr = r_wpos[LEN_W-1:3] + ROW_ADDR_W'(1);
                o_mem_req.be    = win_be[15:8];
                o_mem_req.wdata = win_bits[127:64];
            end
            ST_RD: begin
                o_mem_req.re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_id     <= '0;
            r_fn_id     <= FUNC_IDENT_RST;
            r_receiving <= 1'b0;
            r_total     <= '0;
            r_recv      <= '0;
            r_seq       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RX_IDENT:   r_rx_id <= i_cfg_data;
                    CFG_FUNC_IDENT: r_fn_id <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            r_ovalid <= out_load || (r_ovalid && !o_word.ready);

            case (r_state)
                ST_IDLE: begin
                    if (i_frm.valid) begin
                        r_id    <= i_frm.can_ident;
                        r_dlc   <= i_frm.frame_len;
                        r_d     <= {i_frm.byte_7, i_frm.byte_6, i_frm.byte_5, i_frm.byte_4,
                                    i_frm.byte_3, i_frm.byte_2, i_frm.byte_1, i_frm.byte_0};
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    if (id_hit && dlc_sat != 4'd0) begin
                        case (pci)
                            PCI_SINGLE: begin
                                // a single frame waits here for a free output register
                                if (!sf_ok || out_free) begin
                                    if (sf_ok) begin
                                        r_ob     <= sf_row;
                                        r_obytes <= nib;
                                        r_olen   <= LEN_W'(nib);
                                        r_olast  <= 1'b1;
                                    end
                                    r_state <= ST_IDLE;
                                end
                            end
                            PCI_FIRST: begin
                                if (ff_ok) begin
                                    r_total     <= ff_len[LEN_W-1:0];
                                    r_recv      <= LEN_W'(ff_got);
                                    r_seq       <= 4'd1;
                                    r_receiving <= 1'b1;
                                    r_wpos      <= '0;
                                    r_wcnt      <= ff_got;
                                    r_wdata     <= ff_data;
                                    r_done      <= 1'b0;
                                    r_state     <= ST_WR_LO;
                                end else begin
                                    r_state <= ST_IDLE;
                                end
                            end
                            PCI_CONSEC: begin
                                if (r_receiving && nib == r_seq) begin
                                    r_recv  <= cf_recv_new;
                                    r_seq   <= r_seq + 4'd1;
                                    r_wpos  <= r_recv;
                                    r_wcnt  <= cf_take;
                                    r_wdata <= cf_data;
                                    r_done  <= (cf_recv_new >= r_total);
                                    if (cf_recv_new >= r_total) begin
                                        r_receiving <= 1'b0;
                                    end
                                    r_state <= ST_WR_LO;
                                end else begin
                                    // sequence error drops the message
                                    if (r_receiving) begin
                                        r_receiving <= 1'b0;
                                    end
                                    r_state <= ST_IDLE;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_WR_LO: begin
                    r_state <= ST_WR_HI;
                end
                ST_WR_HI: begin
                    if (r_done) begin
                        r_pos   <= '0;
                        r_state <= ST_RD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    r_state <= ST_RDW;
                end
                ST_RDW: begin
                    if (out_free) begin
                        r_ob     <= drain_row;
                        r_obytes <= drain_n;
                        r_olen   <= r_total;
                        r_olast  <= drain_last;
                        r_pos    <= r_pos + LEN_W'(drain_n);
                        r_state  <= drain_last ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_frm.ready           = (r_state == ST_IDLE);
    assign o_word.valid          = r_ovalid;
    assign o_word.out_0          = r_ob[0];
    assign o_word.out_1          = r_ob[1];
    assign o_word.out_2          = r_ob[2];
    assign o_word.out_3          = r_ob[3];
    assign o_word.out_4          = r_ob[4];
    assign o_word.out_5          = r_ob[5];
    assign o_word.out_6          = r_ob[6];
    assign o_word.out_7          = r_ob[7];
    assign o_word.word_bytes     = r_obytes;
    assign o_word.message_length = r_olen;
    assign o_word.last_word      = r_olast;

endmodule

>>> hw/rtl/isotp_frame_reassembler_unit.sv
// ----------------------------------------------------------------------------
// isotp_frame_reassembler_unit
// iso-tp receive reassembly of can frames into messages of up to MSG_CAP bytes
// ----------------------------------------------------------------------------
// One frame item is taken at a time. A frame that is ignored or a single frame
// goes through capture and decode; a single frame stays in decode for as long
// as the output register still holds a word that has not been taken. An accepted
// first or consecutive frame goes through capture, decode, then one byte-enable
// write to each of the two buffer rows its bytes can span. The last consecutive
// frame of a message is followed by the drain: for each 8-byte word, a read
// state on the single registered read port of the row buffer, then a wait state
// that holds on any output stall; no frame is taken during the drain. The output
// register lets the next frame in while a finished word waits. The buffer has
// no clearing pass: only bytes of the current message are read.
`include "isotp_frame_reassembler_unit_assert.svh"

module isotp_frame_reassembler_unit #(
    parameter int MSG_CAP = isotp_fr_pkg::MSG_CAP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [isotp_fr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [isotp_fr_pkg::ID_W-1:0]       i_cfg_data,
    isotp_fr_in_if.sink                         i_frm,
    isotp_fr_out_if.source                      o_word
);
    import isotp_fr_pkg::*;

    t_mem_req mem_req;
    t_row     mem_rdata;
    logic     mem_busy;
    logic     frm_take;

    isotp_fr_ctrl #(
        .MSG_CAP (MSG_CAP)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_frm     (i_frm),
        .o_word    (o_word),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

    isotp_fr_mem #(
        .MSG_CAP (MSG_CAP)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign mem_busy = mem_req.we || mem_req.re;
    assign frm_take = i_frm.valid && i_frm.ready;

    // buffer writes and reads never overlap
    `ISOTP_FR_ASSERT(a_no_wr_rd, i_clk, i_rst_n, !(mem_req.we && mem_req.re), "write with read")
    // no buffer access while a new frame may be taken
    `ISOTP_FR_ASSERT(a_idle_quiet, i_clk, i_rst_n, !(i_frm.ready && mem_busy), "busy while ready")
    // a taken frame is decoded before the next one
    `ISOTP_FR_ASSERT_NEXT(a_one_frame, i_clk, i_rst_n, frm_take, !i_frm.ready, "back to back")
    // each read is followed by a data cycle
    `ISOTP_FR_ASSERT_NEXT(a_rd_gap, i_clk, i_rst_n, mem_req.re, !mem_req.re, "reads back to back")

endmodule

>>> test/tb_isotp_frame_reassembler_unit.sv
// ----------------------------------------------------------------------------
// tb_isotp_frame_reassembler_unit
// self-checking bench for the iso-tp receive reassembler: drives can frame
// items, predicts the message words in a software copy of the reassembly
// state and compares every delivered word field by field, under random
// idling on both channels and several identifier settings
// ----------------------------------------------------------------------------
module tb_isotp_frame_reassembler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import isotp_fr_pkg::*;

    localparam int MSG_CAP     = MSG_CAP_DEF;
    localparam int ID_MAX      = (1 << ID_W) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 12;
    localparam int BUDGET      = 36;

    localparam logic [3:0] PCI_FLOW = 4'h3;
    localparam logic [3:0] PCI_TOP  = 4'hF;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [DLC_W-1:0] dlc;
        logic [7:0][7:0]  data;
    } can_frame_t;

    typedef struct packed {
        logic [7:0][7:0]  data;
        logic [3:0]       nbytes;
        logic [LEN_W-1:0] msg_len;
        logic             last;
    } msg_word_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ID_W-1:0]      i_cfg_data;

    isotp_fr_in_if  frm_if();
    isotp_fr_out_if word_if();

    isotp_frame_reassembler_unit #(
        .MSG_CAP (MSG_CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frm      (frm_if),
        .o_word     (word_if)
    );

    always #10 i_clk = ~i_clk;

    can_frame_t pending_frames[$];
    msg_word_t  expected_words[$];
    can_frame_t cur_frame;
    int         counted_frames = 0;
    int         error_count    = 0;
    int         stall_cycles   = 0;
    int         sender_idle_pct;
    int         recv_idle_pct;

    // predicted configuration and reassembly state
    logic [ID_W-1:0] rx_ident_q;
    logic [ID_W-1:0] func_ident_q;
    logic            rcv_active;
    int              rcv_total;
    int              rcv_count;
    logic [3:0]      rcv_seq;
    logic [7:0]      msg_store [MSG_CAP];

    function automatic int eff_dlc(input int dlc);
        return (dlc > 8) ? 8 : dlc;
    endfunction

    function automatic void reassemble_frame(input can_frame_t f);
        int        dlc, len, take, pos;
        logic [3:0] pci;
        msg_word_t w;
        dlc = eff_dlc(f.dlc);
        if (f.ident != rx_ident_q && f.ident != func_ident_q) return;
        if (dlc == 0) return;
        pci = f.data[0][7:4];
        case (pci)
            PCI_SINGLE: begin
                len = f.data[0][3:0];
                if (len == 0 || len > SF_MAX_LEN || len > dlc - 1) return;
                w = '0;
                for (int i = 0; i < len; i++) w.data[i] = f.data[i + 1];
                w.nbytes  = 4'(len);
                w.msg_len = LEN_W'(len);
                w.last    = 1'b1;
                expected_words.push_back(w);
            end
            PCI_FIRST: begin
                if (dlc < 2) return;
                len = {f.data[0][3:0], f.data[1]};
                if (len < BYTES_PER_ROW || len > MSG_CAP) return;
                take = dlc - 2;
                if (take > len) take = len;
                for (int i = 0; i < take; i++) msg_store[i] = f.data[2 + i];
                rcv_total  = len;
                rcv_count  = take;
                rcv_seq    = 4'd1;
                rcv_active = 1'b1;
            end
            PCI_CONSEC: begin
                if (!rcv_active) return;
                if (f.data[0][3:0] != rcv_seq) begin
                    rcv_active = 1'b0;
                    return;
                end
                take = dlc - 1;
                if (take > rcv_total - rcv_count) take = rcv_total - rcv_count;
                for (int i = 0; i < take; i++) msg_store[rcv_count + i] = f.data[1 + i];
                rcv_count += take;
                rcv_seq++;
                if (rcv_count >= rcv_total) begin
                    rcv_active = 1'b0;
                    // message complete: walk the buffer eight bytes per word
                    pos = 0;
                    while (pos < rcv_total) begin
                        take = rcv_total - pos;
                        if (take > BYTES_PER_ROW) take = BYTES_PER_ROW;
                        w = '0;
                        for (int i = 0; i < take; i++) w.data[i] = msg_store[pos + i];
                        w.nbytes  = 4'(take);
                        w.msg_len = LEN_W'(rcv_total);
                        pos += take;
                        w.last = (pos >= rcv_total);
                        expected_words.push_back(w);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [ID_W-1:0] pick_ident();
        return $urandom_range(1) ? rx_ident_q : func_ident_q;
    endfunction

    function automatic int random_dlc(input int lo);
        int r;
        r = $urandom_range(15);
        if (r == 0) return $urandom_range(9, 15);
        if (r < 4) return $urandom_range(lo, 7);
        return 8;
    endfunction

    function automatic can_frame_t random_frame(input logic [ID_W-1:0] id, input int dlc);
        can_frame_t f;
        f.ident = id;
        f.dlc   = DLC_W'(dlc);
        for (int i = 0; i < 8; i++) f.data[i] = 8'($urandom);
        return f;
    endfunction

    // directed frame: control byte and first data byte given, the rest filled
    task automatic push_frame(input logic [ID_W-1:0] id, input int dlc, input logic [7:0] b0,
                              input logic [7:0] b1, input int fill);
        can_frame_t f;
        f = random_frame(id, dlc);
        if (fill >= 0) f.data = {8{fill[7:0]}};
        f.data[0] = b0;
        f.data[1] = b1;
        pending_frames.push_back(f);
    endtask

    task automatic queue_message(input int len, input bit broken);
        logic [7:0] payload [MSG_CAP];
        can_frame_t f;
        logic [11:0] len12;
        logic [3:0]  seq;
        int          sent, take, cut, cf_num;
        len12 = 12'(len);
        foreach (payload[i]) payload[i] = 8'($urandom);
        f = random_frame(pick_ident(), random_dlc(2));
        f.data[0] = {PCI_FIRST, len12[11:8]};
        f.data[1] = len12[7:0];
        take = eff_dlc(f.dlc) - 2;
        for (int i = 0; i < take; i++) f.data[2 + i] = payload[i];
        pending_frames.push_back(f);
        counted_frames++;
        sent   = take;
        seq    = 4'd1;
        cf_num = 1;
        cut    = broken ? $urandom_range(1, len / 7 + 1) : 0;
        while (sent < len) begin
            f = random_frame(pick_ident(), random_dlc(1));
            f.data[0] = {PCI_CONSEC, seq};
            if (cf_num == cut) begin
                // either a wrong sequence number or the message just stops
                if ($urandom_range(1)) begin
                    f.data[0][3:0] = seq + 4'($urandom_range(1, 15));
                    pending_frames.push_back(f);
                    counted_frames++;
                end
                break;
            end
            take = eff_dlc(f.dlc) - 1;
            if (take > len - sent) take = len - sent;
            for (int i = 0; i < take; i++) f.data[1 + i] = payload[sent + i];
            pending_frames.push_back(f);
            counted_frames++;
            sent += take;
            seq++;
            cf_num++;
        end
    endtask

    task automatic queue_single();
        can_frame_t f;
        int         len;
        len = $urandom_range(1, SF_MAX_LEN);
        f = random_frame(pick_ident(),
                         ($urandom_range(7) == 0) ? $urandom_range(9, 15) : $urandom_range(len + 1, 8));
        f.data[0] = {PCI_SINGLE, 4'(len)};
        pending_frames.push_back(f);
        counted_frames++;
    endtask

    task automatic queue_noise();
        can_frame_t  f;
        logic [11:0] len12;
        case ($urandom_range(5))
            0: f = random_frame(ID_W'($urandom_range(ID_MAX)), $urandom_range(15));
            1: f = random_frame(pick_ident(), 0);
            2: begin
                f = random_frame(pick_ident(), $urandom_range(1, 15));
                f.data[0][7:4] = PCI_CONSEC;
            end
            3: begin
                f = random_frame(pick_ident(), $urandom_range(1, 15));
                f.data[0][7:4] = 4'($urandom_range(PCI_TOP, PCI_FLOW));
            end
            4: begin
                // first frame that must be dropped
                f = random_frame(pick_ident(), $urandom_range(2, 8));
                case ($urandom_range(2))
                    0: len12 = 12'($urandom_range(0, BYTES_PER_ROW - 1));
                    1: len12 = 12'($urandom_range(MSG_CAP + 1, 4095));
                    default: begin
                        len12 = 12'($urandom_range(BYTES_PER_ROW, MSG_CAP));
                        f.dlc = 4'd1;
                    end
                endcase
                f.data[0] = {PCI_FIRST, len12[11:8]};
                f.data[1] = len12[7:0];
            end
            default: begin
                f = random_frame(pick_ident(), $urandom_range(1, 8));
                f.data[0] = {PCI_SINGLE, 4'($urandom_range(15))};
            end
        endcase
        pending_frames.push_back(f);
    endtask

    task automatic queue_random(input int budget);
        int start, kind;
        start = counted_frames;
        while (counted_frames - start < budget) begin
            kind = $urandom_range(99);
            if (kind < 50)
                queue_message(($urandom_range(19) == 0) ? $urandom_range(200, MSG_CAP)
                                                        : $urandom_range(8, 48),
                              $urandom_range(4) == 0);
            else if (kind < 72)
                queue_single();
            else
                queue_noise();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_RX_IDENT) rx_ident_q = val;
        else func_ident_q = val;
    endtask

    task automatic write_idents(input logic [ID_W-1:0] rx_val, input logic [ID_W-1:0] func_val);
        write_reg(CFG_RX_IDENT, rx_val);
        write_reg(CFG_FUNC_IDENT, func_val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all items taken, all words out, then let the block finish any dropped frame
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_frames.size() != 0 || frm_if.valid || expected_words.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // frame driver
    always @(posedge i_clk) begin
        bit load;
        if (!i_rst_n) begin
            frm_if.valid <= 1'b0;
        end else begin
            if (frm_if.valid && frm_if.ready) reassemble_frame(cur_frame);
            if (!frm_if.valid || frm_if.ready) begin
                load = pending_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct;
                if (load) begin
                    cur_frame = pending_frames.pop_front();
                    frm_if.can_ident <= cur_frame.ident;
                    frm_if.frame_len <= cur_frame.dlc;
                    frm_if.byte_0    <= cur_frame.data[0];
                    frm_if.byte_1    <= cur_frame.data[1];
                    frm_if.byte_2    <= cur_frame.data[2];
                    frm_if.byte_3    <= cur_frame.data[3];
                    frm_if.byte_4    <= cur_frame.data[4];
                    frm_if.byte_5    <= cur_frame.data[5];
                    frm_if.byte_6    <= cur_frame.data[6];
                    frm_if.byte_7    <= cur_frame.data[7];
                end
                frm_if.valid <= load;
            end
        end
    end

    // word monitor
    always @(posedge i_clk) begin
        msg_word_t got, want;
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
        end else begin
            if (word_if.valid && word_if.ready) begin
                got.data = {word_if.out_7, word_if.out_6, word_if.out_5, word_if.out_4,
                            word_if.out_3, word_if.out_2, word_if.out_1, word_if.out_0};
                got.nbytes  = word_if.word_bytes;
                got.msg_len = word_if.message_length;
                got.last    = word_if.last_word;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    for (int i = 0; i < 8; i++)
                        check_field($sformatf("out_%0d", i), want.data[i], got.data[i]);
                    check_field("word_bytes", want.nbytes, got.nbytes);
                    check_field("message_length", want.msg_len, got.msg_len);
                    check_field("last_word", want.last, got.last);
                end
            end
            word_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (frm_if.valid && frm_if.ready)
                || (word_if.valid && word_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("isotp_frame_reassembler_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_RX_IDENT;
        i_cfg_data       = '0;
        frm_if.valid     = 1'b0;
        frm_if.can_ident = '0;
        frm_if.frame_len = '0;
        frm_if.byte_0    = '0;
        frm_if.byte_1    = '0;
        frm_if.byte_2    = '0;
        frm_if.byte_3    = '0;
        frm_if.byte_4    = '0;
        frm_if.byte_5    = '0;
        frm_if.byte_6    = '0;
        frm_if.byte_7    = '0;
        word_if.ready    = 1'b0;
        sender_idle_pct  = 11;
        recv_idle_pct    = 75;
        rx_ident_q       = '0;
        func_ident_q     = FUNC_IDENT_RST;
        rcv_active       = 1'b0;
        rcv_total        = 0;
        rcv_count        = 0;
        rcv_seq          = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames against the reset identifiers
        push_frame(FUNC_IDENT_RST, 8, {PCI_SINGLE, SF_MAX_LEN}, 8'hFF, 8'hFF);
        push_frame('0, 2, {PCI_SINGLE, 4'd1}, 8'h00, 0);
        push_frame('0, 8, {PCI_SINGLE, 4'd0}, 8'h55, -1);
        push_frame('0, 8, {PCI_SINGLE, 4'd8}, 8'h55, -1);
        push_frame(FUNC_IDENT_RST, 4, {PCI_SINGLE, 4'd5}, 8'h55, -1);
        push_frame('0, 15, {PCI_SINGLE, SF_MAX_LEN}, 8'hA5, -1);
        push_frame('0, 0, {PCI_SINGLE, 4'd3}, 8'h11, -1);
        push_frame(ID_W'(ID_MAX), 8, {PCI_SINGLE, 4'd3}, 8'h22, -1);
        push_frame('0, 8, {PCI_CONSEC, 4'd1}, 8'h33, -1);
        push_frame('0, 1, {PCI_FIRST, 4'd0}, 8'h20, -1);
        push_frame('0, 8, {PCI_FIRST, 4'd0}, 8'h07, -1);
        push_frame(FUNC_IDENT_RST, 8, {PCI_FIRST, 4'd1}, 8'h01, -1);
        push_frame('0, 8, {PCI_FIRST, 4'hF}, 8'hFF, -1);
        // shortest message, the consecutive frame overruns it
        push_frame('0, 8, {PCI_FIRST, 4'd0}, 8'h08, -1);
        push_frame('0, 8, {PCI_CONSEC, 4'd1}, 8'h44, -1);
        // sequence error, then a late frame that finds the link idle
        push_frame(FUNC_IDENT_RST, 5, {PCI_FIRST, 4'd0}, 8'h14, -1);
        push_frame('0, 8, {PCI_CONSEC, 4'd1}, 8'h45, -1);
        push_frame('0, 8, {PCI_CONSEC, 4'd3}, 8'h46, -1);
        push_frame(FUNC_IDENT_RST, 8, {PCI_CONSEC, 4'd2}, 8'h47, -1);
        // a first frame restarts a message already in progress
        push_frame('0, 8, {PCI_FIRST, 4'd0}, 8'h10, -1);
        push_frame(FUNC_IDENT_RST, 8, {PCI_FIRST, 4'd0}, 8'h09, -1);
        push_frame('0, 4, {PCI_CONSEC, 4'd1}, 8'h48, -1);
        push_frame('0, 3, {PCI_FLOW, 4'd0}, 8'h00, -1);
        push_frame(FUNC_IDENT_RST, 8, {PCI_TOP, 4'd5}, 8'h49, -1);
        wait_drained();

        write_idents(ID_W'(ID_MAX), '0);
        queue_message(MSG_CAP, 1'b0);
        queue_random(BUDGET);
        wait_drained();

        sender_idle_pct = 75;
        recv_idle_pct   = 11;
        write_idents(ID_W'($urandom_range(ID_MAX)), ID_W'($urandom_range(ID_MAX)));
        queue_random(BUDGET);
        wait_drained();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        write_idents('0, ID_W'(ID_MAX));
        queue_message(MSG_CAP, 1'b0);
        queue_random(BUDGET);
        wait_drained();

        if (error_count == 0)
            $display("isotp_frame_reassembler_unit test passed");
        else
            $display("isotp_frame_reassembler_unit test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/isotp_fr_pkg.sv
hw/rtl/isotp_fr_in_if.sv
hw/rtl/isotp_fr_out_if.sv
hw/rtl/isotp_fr_mem.sv
hw/rtl/isotp_fr_ctrl.sv
hw/rtl/isotp_frame_reassembler_unit.sv
test/tb_isotp_frame_reassembler_unit.sv
